### hdl/greedy_balanced_job_assigner_macros.svh
// Assertion helpers used by the assertions in the job assigner design.
`ifndef GREEDY_BALANCED_JOB_ASSIGNER_MACROS_SVH
`define GREEDY_BALANCED_JOB_ASSIGNER_MACROS_SVH

// Property checked on every clock edge, suspended while reset is high.
`define GBJA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, during reset too.
`define GBJA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/gbja_pkg.sv
package gbja_pkg;

  // Number of workers served in each round.
  localparam int WORKERS = 4;
  localparam int IDX_W   = $clog2(WORKERS);
  localparam int COST_W  = 16;
  localparam int LOAD_W  = 32;

  typedef logic [COST_W-1:0] cost_t;
  typedef logic [LOAD_W-1:0] load_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef cost_t [WORKERS-1:0] cost_vec_t;
  typedef load_t [WORKERS-1:0] load_vec_t;
  typedef idx_t  [WORKERS-1:0] idx_vec_t;

  // Largest value an accumulated load can hold.
  localparam load_t LOAD_MAX = {LOAD_W{1'b1}};

endpackage

### hdl/gbja_if.sv
// Channel that carries one round of job costs.
interface gbja_job_if;
  logic                 valid;
  logic                 ready;
  gbja_pkg::cost_t      job_cost_0;
  gbja_pkg::cost_t      job_cost_1;
  gbja_pkg::cost_t      job_cost_2;
  gbja_pkg::cost_t      job_cost_3;

  modport source (
    output valid, job_cost_0, job_cost_1, job_cost_2, job_cost_3,
    input  ready
  );
  modport sink (
    input  valid, job_cost_0, job_cost_1, job_cost_2, job_cost_3,
    output ready
  );
endinterface

// Channel that carries the assignment of one round.
interface gbja_result_if;
  logic                 valid;
  logic                 ready;
  gbja_pkg::cost_t      assigned_0;
  gbja_pkg::cost_t      assigned_1;
  gbja_pkg::cost_t      assigned_2;
  gbja_pkg::cost_t      assigned_3;
  gbja_pkg::idx_t       round_best;
  gbja_pkg::idx_t       overall_best;

  modport source (
    output valid, assigned_0, assigned_1, assigned_2, assigned_3,
    output round_best, overall_best,
    input  ready
  );
  modport sink (
    input  valid, assigned_0, assigned_1, assigned_2, assigned_3,
    input  round_best, overall_best,
    output ready
  );
endinterface

### hdl/gbja_cost_sort.sv
// Orders the costs of one round from largest to smallest.
module gbja_cost_sort (
  input  gbja_pkg::cost_vec_t cost,
  output gbja_pkg::cost_vec_t sorted
);

  // Exchange sort: each later position that holds a larger cost trades places.
  always_comb begin
    gbja_pkg::cost_t tmp;
    tmp    = '0;
    sorted = cost;
    for (int i = 0; i < gbja_pkg::WORKERS - 1; i++) begin
      for (int j = i + 1; j < gbja_pkg::WORKERS; j++) begin
        if (sorted[j] > sorted[i]) begin
          tmp       = sorted[i];
          sorted[i] = sorted[j];
          sorted[j] = tmp;
        end
      end
    end
  end

endmodule

### hdl/gbja_load_order.sv
// Lists the worker indices from least to most loaded. Ties follow the
// exchange order exactly, so the result is not a stable sort.
module gbja_load_order (
  input  gbja_pkg::load_vec_t load,
  output gbja_pkg::idx_vec_t  order
);

  always_comb begin
    gbja_pkg::load_vec_t key;
    gbja_pkg::load_t     key_tmp;
    gbja_pkg::idx_t      idx_tmp;
    key     = load;
    key_tmp = '0;
    idx_tmp = '0;
    for (int i = 0; i < gbja_pkg::WORKERS; i++) begin
      order[i] = gbja_pkg::IDX_W'(i);
    end
    // Swap a pair whenever the earlier position carries the larger load.
    for (int i = 0; i < gbja_pkg::WORKERS - 1; i++) begin
      for (int j = i + 1; j < gbja_pkg::WORKERS; j++) begin
        if (key[i] > key[j]) begin
          key_tmp  = key[i];
          idx_tmp  = order[i];
          key[i]   = key[j];
          order[i] = order[j];
          key[j]   = key_tmp;
          order[j] = idx_tmp;
        end
      end
    end
  end

endmodule

### hdl/gbja_argmax.sv
// Picks the first worker whose value is the strict maximum above zero.
// When every value is zero the answer is worker zero.
module gbja_argmax (
  input  gbja_pkg::load_vec_t value,
  output gbja_pkg::idx_t      best
);

  always_comb begin
    gbja_pkg::load_t best_val;
    best_val = '0;
    best     = '0;
    for (int i = 0; i < gbja_pkg::WORKERS; i++) begin
      if (value[i] > best_val) begin
        best_val = value[i];
        best     = gbja_pkg::IDX_W'(i);
      end
    end
  end

endmodule

### hdl/greedy_balanced_job_assigner.sv
// Path: a round's result passes through the input register and then the result
// register, and is presented once it reaches the result register.
// Throughput: one round per cycle while the result side does not stall, set by the combinational sort and add path.
// Reset clears all worker loads to zero and empties both register stages.
// A stalled result holds; one further round waits in the input register.
`include "greedy_balanced_job_assigner_macros.svh"

module greedy_balanced_job_assigner (
  input  logic           clk,
  input  logic           rst,
  gbja_job_if.sink       job,
  gbja_result_if.source  result
);

  logic                in_full;
  gbja_pkg::cost_vec_t in_cost;
  gbja_pkg::cost_vec_t in_cost_next;
  logic                out_full;
  gbja_pkg::cost_vec_t given;
  gbja_pkg::cost_vec_t given_next;
  gbja_pkg::load_vec_t worker_load;
  gbja_pkg::load_vec_t worker_load_next;
  gbja_pkg::cost_vec_t sorted;
  gbja_pkg::idx_vec_t  order;
  gbja_pkg::load_vec_t given_wide;
  logic                advance;

  // The held round moves on when the result register is free or being drained.
  assign advance   = in_full && (!out_full || result.ready);
  assign job.ready = !in_full || advance;

  assign in_cost_next[0] = job.job_cost_0;
  assign in_cost_next[1] = job.job_cost_1;
  assign in_cost_next[2] = job.job_cost_2;
  assign in_cost_next[3] = job.job_cost_3;

  gbja_cost_sort u_cost_sort (
    .cost   (in_cost),
    .sorted (sorted)
  );

  gbja_load_order u_load_order (
    .load  (worker_load),
    .order (order)
  );

  // The k-th largest cost goes to the k-th least loaded worker, and the
  // loads grow by the assigned cost, saturating at the top.
  always_comb begin
    logic [gbja_pkg::LOAD_W:0] sum;
    given_next = '0;
    for (int i = 0; i < gbja_pkg::WORKERS; i++) begin
      given_next[order[i]] = sorted[i];
    end
    for (int i = 0; i < gbja_pkg::WORKERS; i++) begin
      sum = {1'b0, worker_load[i]} + (gbja_pkg::LOAD_W + 1)'(given_next[i]);
      worker_load_next[i] = sum[gbja_pkg::LOAD_W] ? gbja_pkg::LOAD_MAX
                                                  : sum[gbja_pkg::LOAD_W-1:0];
    end
  end

  // Control state and worker loads.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full     <= 1'b0;
      out_full    <= 1'b0;
      worker_load <= '0;
    end else begin
      if (job.ready) begin
        in_full <= job.valid;
      end
      if (advance) begin
        out_full    <= 1'b1;
        worker_load <= worker_load_next;
      end else if (result.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (job.valid && job.ready) begin
      in_cost <= in_cost_next;
    end
    if (advance) begin
      given <= given_next;
    end
  end

  // Winners are taken from the registered round, whose loads are the current ones.
  always_comb begin
    for (int i = 0; i < gbja_pkg::WORKERS; i++) begin
      given_wide[i] = gbja_pkg::LOAD_W'(given[i]);
    end
  end

  gbja_argmax u_round_best (
    .value (given_wide),
    .best  (result.round_best)
  );

  gbja_argmax u_overall_best (
    .value (worker_load),
    .best  (result.overall_best)
  );

  assign result.valid      = out_full;
  assign result.assigned_0 = given[0];
  assign result.assigned_1 = given[1];
  assign result.assigned_2 = given[2];
  assign result.assigned_3 = given[3];

  // A blocked round keeps its costs until it moves on.
  `GBJA_ASSERT(held_round_kept, clk, rst,
    in_full && !advance |=> in_full && $stable(in_cost),
    "held round lost or changed")
  // Loads change only together with a transfer into the result register.
  `GBJA_ASSERT(load_only_on_advance, clk, rst,
    !advance |=> $stable(worker_load),
    "loads changed without a round")
  // Saturating accumulation never lowers a load.
  `GBJA_ASSERT(load_monotonic, clk, rst,
    advance |=> (worker_load[0] >= $past(worker_load[0])) &&
    (worker_load[1] >= $past(worker_load[1])) &&
    (worker_load[2] >= $past(worker_load[2])) &&
    (worker_load[3] >= $past(worker_load[3])),
    "a load decreased")

endmodule

### tb/gbja_assign_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the job assigner, keeps its own copy of the
// worker loads, and compares every result transfer against the oldest
// predicted assignment.
module gbja_assign_checker (
  input  logic          clk,
  input  logic          rst,
  gbja_job_if           job,
  gbja_result_if        result,
  output int            fail_count,
  output int            pending_rounds
);

  typedef struct packed {
    gbja_pkg::cost_vec_t given;
    gbja_pkg::idx_t      round_best;
    gbja_pkg::idx_t      overall_best;
  } assignment_t;

  assignment_t         assignment_q[$];
  gbja_pkg::load_vec_t worker_load;
  gbja_pkg::load_vec_t next_load;
  gbja_pkg::cost_vec_t round_costs;
  gbja_pkg::cost_vec_t seen_given;
  assignment_t         want;

  // Works out one round: largest cost to the least loaded worker, with the
  // load order built by a pairwise exchange pass, then saturating loads.
  function automatic assignment_t assign_round(input gbja_pkg::cost_vec_t costs,
                                               input gbja_pkg::load_vec_t loads_in,
                                               output gbja_pkg::load_vec_t loads_out);
    gbja_pkg::cost_vec_t       sorted;
    gbja_pkg::load_vec_t       key;
    gbja_pkg::idx_vec_t        order;
    assignment_t               res;
    gbja_pkg::cost_t           c_tmp;
    gbja_pkg::load_t           l_tmp;
    gbja_pkg::idx_t            i_tmp;
    logic [gbja_pkg::LOAD_W:0] sum;
    gbja_pkg::cost_t           top_cost;
    gbja_pkg::load_t           top_load;
    sorted = costs;
    key    = loads_in;
    for (int i = 0; i < gbja_pkg::WORKERS; i++) order[i] = gbja_pkg::idx_t'(i);

    // Costs in descending order.
    for (int i = 0; i < gbja_pkg::WORKERS - 1; i++)
      for (int j = i + 1; j < gbja_pkg::WORKERS; j++)
        if (sorted[j] > sorted[i]) begin
          c_tmp     = sorted[i];
          sorted[i] = sorted[j];
          sorted[j] = c_tmp;
        end

    // Workers by load, ascending; ties follow the exchange order exactly.
    for (int i = 0; i < gbja_pkg::WORKERS; i++)
      for (int j = i + 1; j < gbja_pkg::WORKERS; j++)
        if (key[i] > key[j]) begin
          l_tmp    = key[i];
          i_tmp    = order[i];
          key[i]   = key[j];
          order[i] = order[j];
          key[j]   = l_tmp;
          order[j] = i_tmp;
        end

    res.given = '0;
    for (int i = 0; i < gbja_pkg::WORKERS; i++) res.given[order[i]] = sorted[i];

    // Accumulate with saturation at the top of the load range.
    for (int i = 0; i < gbja_pkg::WORKERS; i++) begin
      sum          = {1'b0, loads_in[i]} +
                     {{(gbja_pkg::LOAD_W - gbja_pkg::COST_W + 1){1'b0}}, res.given[i]};
      loads_out[i] = sum[gbja_pkg::LOAD_W] ? gbja_pkg::LOAD_MAX
                                           : sum[gbja_pkg::LOAD_W-1:0];
    end

    // Leaders must be strictly above zero; the first of equal maxima wins.
    top_cost       = '0;
    res.round_best = '0;
    for (int i = 0; i < gbja_pkg::WORKERS; i++)
      if (res.given[i] > top_cost) begin
        top_cost       = res.given[i];
        res.round_best = gbja_pkg::idx_t'(i);
      end
    top_load         = '0;
    res.overall_best = '0;
    for (int i = 0; i < gbja_pkg::WORKERS; i++)
      if (loads_out[i] > top_load) begin
        top_load         = loads_out[i];
        res.overall_best = gbja_pkg::idx_t'(i);
      end
    return res;
  endfunction

  task automatic report_field(input string field, input longint unsigned exp_val,
                              input longint unsigned act_val);
    $error("%s mismatch: expected %0h, got %0h", field, exp_val, act_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      worker_load = '0;
      assignment_q.delete();
      fail_count = 0;
    end else begin
      // A job transfer adds one predicted assignment.
      if (job.valid && job.ready) begin
        round_costs = {job.job_cost_3, job.job_cost_2, job.job_cost_1, job.job_cost_0};
        assignment_q.push_back(assign_round(round_costs, worker_load, next_load));
        worker_load = next_load;
      end

      // A result transfer is checked against the oldest prediction.
      if (result.valid && result.ready) begin
        if (assignment_q.size() == 0) begin
          $error("result transfer with no round outstanding");
          fail_count++;
        end else begin
          want       = assignment_q.pop_front();
          seen_given = {result.assigned_3, result.assigned_2,
                        result.assigned_1, result.assigned_0};
          for (int i = 0; i < gbja_pkg::WORKERS; i++)
            if (seen_given[i] !== want.given[i])
              report_field($sformatf("assigned_%0d", i), want.given[i], seen_given[i]);
          if (result.round_best !== want.round_best)
            report_field("round_best", want.round_best, result.round_best);
          if (result.overall_best !== want.overall_best)
            report_field("overall_best", want.overall_best, result.overall_best);
        end
      end
    end
    pending_rounds <= assignment_q.size();
  end

endmodule

### tb/greedy_balanced_job_assigner_tb.sv
`timescale 1ns / 1ps

module greedy_balanced_job_assigner_tb;

  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int PHASE_ROUNDS     = 445;
  localparam int DRAIN_LIMIT      = 2000;
  localparam int TIMEOUT_NS       = 5000000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_rounds;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_off_requests;
  int   hold_offs_started;
  int   hold_left;

  gbja_job_if    job_ch ();
  gbja_result_if result_ch ();

  greedy_balanced_job_assigner u_top (
    .clk    (clk),
    .rst    (rst),
    .job    (job_ch),
    .result (result_ch)
  );

  gbja_assign_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .job            (job_ch),
    .result         (result_ch),
    .fail_count     (fail_count),
    .pending_rounds (pending_rounds)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready   <= 1'b0;
      hold_offs_started <= 0;
      hold_left         <= 0;
    end else if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (hold_off_requests != hold_offs_started) begin
      result_ch.ready   <= 1'b0;
      hold_offs_started <= hold_offs_started + 1;
      hold_left         <= HOLD_OFF_CYCLES - 1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one round, idling first at the current rate, and returns on transfer.
  task automatic send_round(input gbja_pkg::cost_vec_t costs);
    while ($urandom_range(99) < send_idle_pct) begin
      job_ch.valid <= 1'b0;
      @(posedge clk);
    end
    job_ch.valid      <= 1'b1;
    job_ch.job_cost_0 <= costs[0];
    job_ch.job_cost_1 <= costs[1];
    job_ch.job_cost_2 <= costs[2];
    job_ch.job_cost_3 <= costs[3];
    @(posedge clk);
    while (!job_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted round has come back, or until DRAIN_LIMIT runs out.
  task automatic wait_results_drained();
    int cycles;
    cycles = 0;
    job_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rounds != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
  endtask

  // Mix of full-range costs, corner values, equal costs, near-zero costs and rounds with a single nonzero cost.
  function automatic gbja_pkg::cost_vec_t random_costs();
    gbja_pkg::cost_vec_t c;
    int                  kind;
    gbja_pkg::cost_t     shared;
    kind   = $urandom_range(9);
    shared = gbja_pkg::cost_t'($urandom);
    for (int i = 0; i < gbja_pkg::WORKERS; i++) begin
      case (kind)
        5, 6:    case ($urandom_range(3))
                   0: c[i] = '0;
                   1: c[i] = gbja_pkg::cost_t'(1);
                   2: c[i] = {1'b1, {(gbja_pkg::COST_W - 1){1'b0}}};
                   default: c[i] = '1;
                 endcase
        7:       c[i] = shared;
        8:       c[i] = gbja_pkg::cost_t'($urandom_range(3));
        default: c[i] = gbja_pkg::cost_t'($urandom);
      endcase
    end
    if (kind == 9) begin
      c = '0;
      c[$urandom_range(gbja_pkg::WORKERS - 1)] = gbja_pkg::cost_t'($urandom);
    end
    return c;
  endfunction

  task automatic run_random(input int send_pct, input int recv_pct, input int rounds);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    repeat (rounds) send_round(random_costs());
  endtask

  initial begin
    gbja_pkg::cost_vec_t directed [$];
    directed = '{
      {16'h0000, 16'h0000, 16'h0000, 16'h0000},
      {16'h0000, 16'h0000, 16'h0000, 16'h0000},
      {16'h0001, 16'h0001, 16'h0000, 16'h0000},
      {16'h0000, 16'h0000, 16'h0001, 16'h0001},
      {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      {16'h0000, 16'h0000, 16'h0000, 16'hFFFF},
      {16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
      {16'h0004, 16'h0003, 16'h0002, 16'h0001},
      {16'h0001, 16'h0002, 16'h0003, 16'h0004},
      {16'h8000, 16'h8000, 16'h8000, 16'h8000},
      {16'h0008, 16'h0004, 16'h0002, 16'h0001},
      {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
      {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
      {16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE},
      {16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000},
      {16'h0000, 16'h0000, 16'h0000, 16'h0000}
    };
    rst               = 1'b1;
    job_ch.valid      = 1'b0;
    job_ch.job_cost_0 = '0;
    job_ch.job_cost_1 = '0;
    job_ch.job_cost_2 = '0;
    job_ch.job_cost_3 = '0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_off_requests = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner rounds first, starting from equal (zero) loads.
    foreach (directed[i]) send_round(directed[i]);

    // Long result hold-off while rounds keep coming, so the input backs up.
    hold_off_requests <= hold_off_requests + 1;
    run_random(17, 46, PHASE_ROUNDS);
    wait_results_drained();

    run_random(46, 17, PHASE_ROUNDS);
    run_random(0, 0, PHASE_ROUNDS);

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_rounds == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
